// ----- rtl/variable_partition_allocator_macros.svh -----
// Assertion macros shared by the allocator modules.
`ifndef VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define VPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// The antecedent implies the consequent in the next cycle.
`define VPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ----- rtl/vpa_pkg.sv -----
package vpa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int ADDR_BITS_DEF    = 20;
    localparam int AMT_W            = 21;
    localparam int ID_W             = 16;
    localparam int ST_W             = 3;
    localparam int REQ_W            = 3;

    localparam logic [ID_W-1:0] ID_MAX = 16'hFFFF;

    localparam logic [REQ_W-1:0] REQ_FIRST = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BEST  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WORST = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FREE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INIT  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_NOFIT = 3'd1;
    localparam logic [ST_W-1:0] ST_BADID = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 3'd3;
    localparam logic [ST_W-1:0] ST_ZERO  = 3'd4;

    localparam logic [2:0] WS_MOVE  = 3'd0;
    localparam logic [2:0] WS_PICK  = 3'd1;
    localparam logic [2:0] WS_SPLIT = 3'd2;
    localparam logic [2:0] WS_MERGE = 3'd3;
    localparam logic [2:0] WS_INIT  = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [AMT_W-1:0] amount;
        logic [ID_W-1:0]  release_id;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [ID_W-1:0] granted_id;
    } rsp_t;

    typedef struct packed {
        logic            load;
        logic            eval;
        logic            cap_next;
        logic            rd_en;
        logic            wr_en;
        logic [2:0]      wr_sel;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            init;
        logic            finish;
        logic            grant;
        logic [ST_W-1:0] st;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             amt_zero;
        logic             rid_zero;
        logic             cnt_zero;
        logic             hit;
        logic             found;
        logic             split;
        logic             full;
        logic             pf;
        logic             nf;
    } sts_t;

endpackage

// ----- rtl/vpa_datapath.sv -----
`include "variable_partition_allocator_macros.svh"

module vpa_datapath import vpa_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF,
    localparam int IW = $clog2(MAX_SEGMENTS),
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  req_t          req,
    input  cmd_t          cmd,
    input  logic [IW-1:0] rd_addr,
    input  logic [IW-1:0] wr_addr,
    input  logic [IW-1:0] eval_idx,
    output sts_t          sts,
    output logic [CW-1:0] count,
    output logic [IW-1:0] pick_idx,
    output logic          done,
    output rsp_t          rsp
);

    localparam int SW   = ADDR_BITS + 1;
    localparam int CMPW = (SW > AMT_W) ? SW : AMT_W;
    localparam int EW   = ADDR_BITS + SW + 1 + ID_W;

    logic [EW-1:0] mem [MAX_SEGMENTS];
    logic [EW-1:0] rd_data_reg;
    logic [EW-1:0] wr_data;

    req_t             req_reg;
    logic [CW-1:0]    count_reg;
    logic [ID_W-1:0]  next_id_reg;
    logic             found_reg;
    logic             done_reg;
    rsp_t             rsp_reg;
    logic [IW-1:0]    pick_idx_reg;
    logic [ADDR_BITS-1:0] pick_start_reg;
    logic [SW-1:0]    pick_size_reg;
    logic             prev_free_reg;
    logic [ADDR_BITS-1:0] prev_start_reg;
    logic [SW-1:0]    prev_size_reg;
    logic             nxt_free_reg;
    logic [SW-1:0]    nxt_size_reg;

    logic [ADDR_BITS-1:0] rd_start;
    logic [SW-1:0]    rd_size;
    logic             rd_free;
    logic [ID_W-1:0]  rd_owner;
    logic [CMPW-1:0]  amt_c;
    logic [CMPW-1:0]  lim_c;
    logic [CMPW-1:0]  init_c;
    logic [SW-1:0]    amt_s;
    logic             fit;
    logic             fhit;
    logic             better;
    logic             is_free;
    logic             take;
    logic             pf;
    logic [CW-1:0]    dlt;
    logic [SW-1:0]    merge_size;

    assign rd_start = rd_data_reg[EW-1 -: ADDR_BITS];
    assign rd_size  = rd_data_reg[ID_W+1 +: SW];
    assign rd_free  = rd_data_reg[ID_W];
    assign rd_owner = rd_data_reg[ID_W-1:0];

    assign amt_c  = CMPW'(req_reg.amount);
    assign amt_s  = SW'(req_reg.amount);
    assign lim_c  = CMPW'(1) << ADDR_BITS;
    assign init_c = (amt_c > lim_c) ? lim_c : amt_c;

    assign is_free = (req_reg.req_type == REQ_FREE);
    assign fit     = rd_free && (CMPW'(rd_size) >= amt_c);
    assign fhit    = !rd_free && (rd_owner == req_reg.release_id);
    assign better  = !found_reg
                  || ((req_reg.req_type == REQ_BEST) && (rd_size < pick_size_reg))
                  || ((req_reg.req_type == REQ_WORST) && (rd_size > pick_size_reg));
    assign take    = is_free ? fhit : (fit && better);

    assign pf  = (pick_idx_reg != '0) && prev_free_reg;
    assign dlt = CW'(pf) + CW'(nxt_free_reg);
    assign merge_size = (pf ? prev_size_reg : '0) + pick_size_reg
                      + (nxt_free_reg ? nxt_size_reg : '0);

    always_comb
    begin
        case (cmd.wr_sel)
            WS_PICK:  wr_data = {pick_start_reg, amt_s, 1'b0, next_id_reg};
            WS_SPLIT: wr_data = {pick_start_reg + ADDR_BITS'(req_reg.amount),
                                 pick_size_reg - amt_s, 1'b1, {ID_W{1'b0}}};
            WS_MERGE: wr_data = {(pf ? prev_start_reg : pick_start_reg), merge_size,
                                 1'b1, {ID_W{1'b0}}};
            WS_INIT:  wr_data = {{ADDR_BITS{1'b0}}, SW'(init_c), 1'b1, {ID_W{1'b0}}};
            default:  wr_data = rd_data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.eval)
        begin
            if (take)
            begin
                pick_idx_reg   <= eval_idx;
                pick_start_reg <= rd_start;
                pick_size_reg  <= rd_size;
            end
            if (!(is_free && fhit))
            begin
                prev_free_reg  <= rd_free;
                prev_start_reg <= rd_start;
                prev_size_reg  <= rd_size;
            end
        end
        if (cmd.cap_next)
        begin
            nxt_free_reg <= (CW'(pick_idx_reg) + CW'(1) < count_reg) && rd_free;
            nxt_size_reg <= rd_size;
        end
        if (cmd.finish)
        begin
            rsp_reg.status     <= cmd.st;
            rsp_reg.granted_id <= cmd.grant ? next_id_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            next_id_reg <= ID_W'(1);
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.eval && take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.init)
            begin
                count_reg   <= (req_reg.amount == '0) ? '0 : CW'(1);
                next_id_reg <= ID_W'(1);
            end
            else if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - dlt;
            end
            if (cmd.grant)
            begin
                next_id_reg <= (next_id_reg == ID_MAX) ? ID_W'(1) : next_id_reg + ID_W'(1);
            end
        end
    end

    assign sts.req_type = req_reg.req_type;
    assign sts.amt_zero = (req_reg.amount == '0);
    assign sts.rid_zero = (req_reg.release_id == '0);
    assign sts.cnt_zero = (count_reg == '0);
    assign sts.hit      = is_free ? fhit : fit;
    assign sts.found    = found_reg;
    assign sts.split    = CMPW'(pick_size_reg) > amt_c;
    assign sts.full     = (count_reg >= CW'(MAX_SEGMENTS));
    assign sts.pf       = pf;
    assign sts.nf       = nxt_free_reg;

    assign count    = count_reg;
    assign pick_idx = pick_idx_reg;
    assign done     = done_reg;
    assign rsp      = rsp_reg;

    `VPA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_SEGMENTS))
    `VPA_ASSERT_NOW(a_id_nonzero, 1'b1, next_id_reg != '0)
    `VPA_ASSERT_NEXT(a_grant_ok, cmd.grant, done_reg && (rsp_reg.status == ST_OK))

endmodule

// ----- rtl/vpa_ctrl.sv -----
`include "variable_partition_allocator_macros.svh"

module vpa_ctrl import vpa_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    localparam int IW = $clog2(MAX_SEGMENTS),
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sts_t          sts,
    input  logic [CW-1:0] count,
    input  logic [IW-1:0] pick_idx,
    output cmd_t          cmd,
    output logic [IW-1:0] rd_addr,
    output logic [IW-1:0] wr_addr,
    output logic [IW-1:0] eval_idx
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_AL_DEC = 4'd3;
    localparam logic [3:0] S_FR_NXT = 4'd4;
    localparam logic [3:0] S_FR_DEC = 4'd5;
    localparam logic [3:0] S_MOVE   = 4'd6;
    localparam logic [3:0] S_SPLIT  = 4'd7;
    localparam logic [3:0] S_PICK   = 4'd8;
    localparam logic [3:0] S_FR_FIN = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [3:0]    after_reg, after_next;
    logic [CW-1:0] rptr_reg, rptr_next;
    logic [IW-1:0] eidx_reg, eidx_next;
    logic          ev_v_reg, ev_v_next;
    logic [IW-1:0] src_reg, src_next;
    logic [IW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic          pend_reg, pend_next;
    logic          up_reg, up_next;
    logic [1:0]    dlt_reg, dlt_next;

    logic          scan_rd;
    logic          last;
    logic          stop;
    logic [IW-1:0] tgt;
    logic [CW-1:0] base;

    assign scan_rd = (rptr_reg < count);
    assign last    = (CW'(eidx_reg) + CW'(1) == count);
    assign stop    = sts.hit && ((sts.req_type == REQ_FIRST) || (sts.req_type == REQ_FREE));
    assign tgt     = sts.pf ? pick_idx - IW'(1) : pick_idx;
    assign base    = CW'(tgt) + CW'(1) + CW'(sts.pf) + CW'(sts.nf);

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        rptr_next  = rptr_reg;
        eidx_next  = eidx_reg;
        ev_v_next  = 1'b0;
        src_next   = src_reg;
        wptr_next  = wptr_reg;
        rem_next   = rem_reg;
        pend_next  = pend_reg;
        up_next    = up_reg;
        dlt_next   = dlt_reg;
        cmd        = '0;
        cmd.wr_sel = WS_MOVE;
        cmd.st     = ST_OK;
        rd_addr    = src_reg;
        wr_addr    = wptr_reg;
        eval_idx   = eidx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                rptr_next = '0;
                case (sts.req_type)
                    REQ_FIRST, REQ_BEST, REQ_WORST:
                    begin
                        if (sts.amt_zero)
                        begin
                            cmd.finish = 1'b1;
                            cmd.st     = ST_ZERO;
                            state_next = S_IDLE;
                        end
                        else if (sts.cnt_zero)
                        begin
                            cmd.finish = 1'b1;
                            cmd.st     = ST_NOFIT;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    REQ_FREE:
                    begin
                        if (sts.rid_zero || sts.cnt_zero)
                        begin
                            cmd.finish = 1'b1;
                            cmd.st     = ST_BADID;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    REQ_INIT:
                    begin
                        cmd.init   = 1'b1;
                        cmd.wr_en  = !sts.amt_zero;
                        cmd.wr_sel = WS_INIT;
                        wr_addr    = '0;
                        cmd.finish = 1'b1;
                        cmd.st     = sts.amt_zero ? ST_ZERO : ST_OK;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                rd_addr   = rptr_reg[IW-1:0];
                cmd.rd_en = scan_rd;
                cmd.eval  = ev_v_reg;
                if (scan_rd)
                begin
                    rptr_next = rptr_reg + CW'(1);
                    eidx_next = rptr_reg[IW-1:0];
                end
                if (ev_v_reg && stop)
                begin
                    state_next = (sts.req_type == REQ_FREE) ? S_FR_NXT : S_AL_DEC;
                end
                else if (ev_v_reg && last)
                begin
                    if (sts.req_type == REQ_FREE)
                    begin
                        cmd.finish = 1'b1;
                        cmd.st     = ST_BADID;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_AL_DEC;
                    end
                end
                else
                begin
                    ev_v_next = scan_rd;
                end
            end
            S_AL_DEC:
            begin
                if (!sts.found)
                begin
                    cmd.finish = 1'b1;
                    cmd.st     = ST_NOFIT;
                    state_next = S_IDLE;
                end
                else if (sts.split && sts.full)
                begin
                    cmd.finish = 1'b1;
                    cmd.st     = ST_FULL;
                    state_next = S_IDLE;
                end
                else if (sts.split)
                begin
                    up_next    = 1'b1;
                    src_next   = IW'(count - CW'(1));
                    rem_next   = count - CW'(1) - CW'(pick_idx);
                    pend_next  = 1'b0;
                    after_next = S_SPLIT;
                    state_next = S_MOVE;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end
            S_FR_NXT:
            begin
                cmd.cap_next = 1'b1;
                state_next   = S_FR_DEC;
            end
            S_FR_DEC:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WS_MERGE;
                wr_addr    = tgt;
                up_next    = 1'b0;
                dlt_next   = 2'(sts.pf) + 2'(sts.nf);
                src_next   = base[IW-1:0];
                rem_next   = count - base;
                pend_next  = 1'b0;
                after_next = S_FR_FIN;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.rd_en = (rem_reg != '0);
                cmd.wr_en = pend_reg;
                pend_next = (rem_reg != '0);
                if (rem_reg != '0)
                begin
                    rem_next  = rem_reg - CW'(1);
                    src_next  = up_reg ? src_reg - IW'(1) : src_reg + IW'(1);
                    wptr_next = up_reg ? src_reg + IW'(1) : src_reg - IW'(dlt_reg);
                end
                else if (!pend_reg)
                begin
                    state_next = after_reg;
                end
            end
            S_SPLIT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WS_SPLIT;
                wr_addr     = pick_idx + IW'(1);
                cmd.cnt_inc = 1'b1;
                state_next  = S_PICK;
            end
            S_PICK:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WS_PICK;
                wr_addr    = pick_idx;
                cmd.grant  = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_FR_FIN:
            begin
                cmd.cnt_dec = 1'b1;
                cmd.finish  = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            after_reg <= S_IDLE;
            rptr_reg  <= '0;
            eidx_reg  <= '0;
            ev_v_reg  <= 1'b0;
            src_reg   <= '0;
            wptr_reg  <= '0;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
            up_reg    <= 1'b0;
            dlt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            rptr_reg  <= rptr_next;
            eidx_reg  <= eidx_next;
            ev_v_reg  <= ev_v_next;
            src_reg   <= src_next;
            wptr_reg  <= wptr_next;
            rem_reg   <= rem_next;
            pend_reg  <= pend_next;
            up_reg    <= up_next;
            dlt_reg   <= dlt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `VPA_ASSERT_NOW(a_idle_quiet, state_reg == S_IDLE, !cmd.wr_en && !cmd.rd_en)
    `VPA_ASSERT_NEXT(a_finish_idle, cmd.finish, state_reg == S_IDLE)
    `VPA_ASSERT_NOW(a_move_apart, (state_reg == S_MOVE) && cmd.rd_en && cmd.wr_en,
        rd_addr != wr_addr)

endmodule

// ----- rtl/variable_partition_allocator.sv -----
// Segment allocator with first, best and worst fit and merging on release.
// Requests enter on start with the req struct and are taken when busy is low.
// req_type selects first fit, best fit, worst fit, free or init; amount is the
// request size or the managed memory size, and release_id names the item to
// release. Every request produces exactly one result: done is high for one
// cycle with rsp carrying status and granted_id, and the receiver cannot
// stall it, so a result is never held back.
// The time a request takes is set by the scan of the segment table over the
// live segments and, when a split or a merge moves the table tail, by the
// shift, which moves one entry per cycle, plus bookkeeping around the shift.
// busy stays high until the result is produced, and the result appears in
// the cycle in which busy falls.
// Reset empties the table and restarts the id counter at one; no clearing
// pass is needed since only live entries are ever read.
module variable_partition_allocator import vpa_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    cmd_t          cmd;
    sts_t          sts;
    logic [CW-1:0] count;
    logic [IW-1:0] pick_idx;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] eval_idx;

    vpa_ctrl #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .sts      (sts),
        .count    (count),
        .pick_idx (pick_idx),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .eval_idx (eval_idx)
    );

    vpa_datapath #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .eval_idx (eval_idx),
        .sts      (sts),
        .count    (count),
        .pick_idx (pick_idx),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import vpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEGS = MAX_SEGMENTS_DEF;
    localparam logic [AMT_W-1:0] MEM_LIMIT = 21'd1 << ADDR_BITS_DEF;
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    req_t req = '0;
    rsp_t rsp;

    logic [AMT_W-1:0] part_size [SEGS];
    bit               part_free [SEGS];
    logic [ID_W-1:0]  part_owner [SEGS];
    int               part_count = 0;
    logic [ID_W-1:0]  id_next = ID_W'(1);

    rsp_t        pending_rsp [$];
    logic [ID_W-1:0] live_ids [$];
    row_t        plan [$];
    int          errors = 0;
    int          idle_pct = 0;

    variable_partition_allocator DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .rsp(rsp)
    );

    always #4 clk = ~clk;

    function automatic void drop_part(int pos);
        for (int k = pos; k + 1 < part_count; k++)
        begin
            part_size[k] = part_size[k + 1];
            part_free[k] = part_free[k + 1];
            part_owner[k] = part_owner[k + 1];
        end
        part_count--;
    endfunction

    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        int pick;
        bit found;
        logic [AMT_W-1:0] amt;
        res = '0;
        pick = 0;
        found = 0;
        amt = r.amount;
        if (r.req_type <= REQ_WORST)
        begin
            if (amt == 0)
                res.status = ST_ZERO;
            else
            begin
                for (int k = 0; k < part_count; k++)
                begin
                    if (!part_free[k] || part_size[k] < amt)
                        continue;
                    if (!found)
                    begin
                        pick = k;
                        found = 1;
                        if (r.req_type == REQ_FIRST)
                            break;
                    end
                    else if (r.req_type == REQ_BEST && part_size[k] < part_size[pick])
                        pick = k;
                    else if (r.req_type == REQ_WORST && part_size[k] > part_size[pick])
                        pick = k;
                end
                if (!found)
                    res.status = ST_NOFIT;
                else if (part_size[pick] > amt && part_count >= SEGS)
                    res.status = ST_FULL;
                else
                begin
                    if (part_size[pick] > amt)
                    begin
                        for (int k = part_count; k > pick + 1; k--)
                        begin
                            part_size[k] = part_size[k - 1];
                            part_free[k] = part_free[k - 1];
                            part_owner[k] = part_owner[k - 1];
                        end
                        part_size[pick + 1] = part_size[pick] - amt;
                        part_free[pick + 1] = 1;
                        part_owner[pick + 1] = '0;
                        part_count++;
                        part_size[pick] = amt;
                    end
                    part_free[pick] = 0;
                    part_owner[pick] = id_next;
                    res.granted_id = id_next;
                    id_next = (id_next == ID_MAX) ? 16'd1 : id_next + 16'd1;
                end
            end
        end
        else if (r.req_type == REQ_FREE)
        begin
            for (int k = 0; k < part_count && r.release_id != 0; k++)
            begin
                if (!part_free[k] && part_owner[k] == r.release_id)
                begin
                    pick = k;
                    found = 1;
                    break;
                end
            end
            if (!found)
                res.status = ST_BADID;
            else
            begin
                part_free[pick] = 1;
                part_owner[pick] = '0;
                if (pick > 0 && part_free[pick - 1])
                begin
                    part_size[pick - 1] += part_size[pick];
                    drop_part(pick);
                    pick--;
                end
                if (pick + 1 < part_count && part_free[pick + 1])
                begin
                    part_size[pick] += part_size[pick + 1];
                    drop_part(pick + 1);
                end
            end
        end
        else if (r.req_type == REQ_INIT)
        begin
            id_next = ID_W'(1);
            if (amt == 0)
            begin
                part_count = 0;
                res.status = ST_ZERO;
            end
            else
            begin
                part_size[0] = (amt > MEM_LIMIT) ? MEM_LIMIT : amt;
                part_free[0] = 1;
                part_owner[0] = '0;
                part_count = 1;
            end
        end
        return res;
    endfunction

    function automatic row_t mk(logic [REQ_W-1:0] t, int amt, int rid, bit typed = 0,
                                logic [ST_W-1:0] st = ST_OK, int gid = 0);
        row_t x;
        x.r.req_type = t;
        x.r.amount = AMT_W'(amt);
        x.r.release_id = ID_W'(rid);
        x.typed = typed;
        x.want.status = st;
        x.want.granted_id = ID_W'(gid);
        return x;
    endfunction

    task automatic issue(req_t r, bit typed = 0, rsp_t want = '0);
        rsp_t pred;
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        pred = apply_request(r);
        pending_rsp.push_back(typed ? want : pred);
        if (r.req_type == REQ_INIT)
            live_ids.delete();
        else if (r.req_type <= REQ_WORST && pred.status == ST_OK)
            live_ids.push_back(pred.granted_id);
        else if (r.req_type == REQ_FREE && pred.status == ST_OK)
        begin
            foreach (live_ids[i])
            begin
                if (live_ids[i] == r.release_id)
                begin
                    live_ids.delete(i);
                    break;
                end
            end
        end
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    function automatic req_t random_request();
        req_t r;
        int pick;
        r.release_id = ID_W'($urandom);
        r.amount = AMT_W'($urandom_range(1, 16));
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            r.req_type = REQ_W'($urandom_range(REQ_FIRST, REQ_WORST));
            if ($urandom_range(0, 9) < 2)
                r.amount = AMT_W'($urandom_range(0, 600));
            else if ($urandom_range(0, 9) == 0)
                r.amount = AMT_W'($urandom);
        end
        else if (pick < 93)
        begin
            r.req_type = REQ_FREE;
            if (live_ids.size() > 0 && $urandom_range(0, 9) < 8)
                r.release_id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        end
        else if (pick < 97)
        begin
            r.req_type = REQ_INIT;
            case ($urandom_range(0, 5))
                0: r.amount = '0;
                1: r.amount = AMT_W'($urandom);
                default: r.amount = AMT_W'($urandom_range(64, 2048));
            endcase
        end
        else
            r.req_type = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        return r;
    endfunction

    task automatic drain();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result status=%0d id=%0d", rsp.status, rsp.granted_id);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status || rsp.granted_id !== want.granted_id)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected status=%0d id=%0d, got status=%0d id=%0d",
                                 want.status, want.granted_id, rsp.status, rsp.granted_id);
                end
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int rounds;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back(mk(REQ_FIRST, 5, 0, 1, ST_NOFIT));
        plan.push_back(mk(REQ_FREE, 0, 0, 1, ST_BADID));
        plan.push_back(mk(REQ_INIT, 0, 0, 1, ST_ZERO));
        plan.push_back(mk(REQ_BEST, 1, 0, 1, ST_NOFIT));
        plan.push_back(mk(REQ_SPARE_LO, 3, 7, 1, ST_OK));
        plan.push_back(mk(REQ_SPARE_HI, 21'h1FFFFF, 16'hFFFF, 1, ST_OK));
        plan.push_back(mk(REQ_INIT, 21'h1FFFFF, 0, 1, ST_OK));
        plan.push_back(mk(REQ_FIRST, 0, 0, 1, ST_ZERO));
        plan.push_back(mk(REQ_WORST, MEM_LIMIT, 0, 1, ST_OK, 1));
        plan.push_back(mk(REQ_FIRST, 1, 0, 1, ST_NOFIT));
        plan.push_back(mk(REQ_FREE, 0, 1, 1, ST_OK));
        plan.push_back(mk(REQ_FREE, 0, 1, 1, ST_BADID));
        plan.push_back(mk(REQ_FREE, 0, 16'hFFFF, 1, ST_BADID));
        plan.push_back(mk(REQ_INIT, 100, 0, 1, ST_OK));
        plan.push_back(mk(REQ_FIRST, 10, 0));
        plan.push_back(mk(REQ_FIRST, 20, 0));
        plan.push_back(mk(REQ_FIRST, 30, 0));
        plan.push_back(mk(REQ_FREE, 0, 1));
        plan.push_back(mk(REQ_FREE, 0, 3));
        plan.push_back(mk(REQ_BEST, 5, 0));
        plan.push_back(mk(REQ_WORST, 5, 0));
        plan.push_back(mk(REQ_FIRST, 10, 0));
        plan.push_back(mk(REQ_FIRST, 21'h1FFFFF, 0, 1, ST_NOFIT));
        plan.push_back(mk(REQ_FREE, 0, 2));
        foreach (plan[i])
            issue(plan[i].r, plan[i].typed, plan[i].want);
        drain();

        // Fill the table with single-unit items until a split is refused.
        issue(mk(REQ_INIT, 200, 0).r);
        for (int i = 0; i < SEGS + 2; i++)
            issue(mk(REQ_FIRST, 1, 0).r);
        issue(mk(REQ_FIRST, 200, 0).r);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 78;
                2: idle_pct = 0;
                default: idle_pct = 26;
            endcase
            issue(mk(REQ_INIT, $urandom_range(128, 1024), 0).r);
            for (int i = 0; i < 500; i++)
                issue(random_request());
        end

        start <= 1'b0;
        rounds = 0;
        while (pending_rsp.size() != 0 && rounds < 100_000)
        begin
            @(posedge clk);
            rounds++;
        end
        repeat (150) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/vpa_pkg.sv
rtl/vpa_datapath.sv
rtl/vpa_ctrl.sv
rtl/variable_partition_allocator.sv
tb/testbench.sv
